>>> design/rbfe_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package rbfe_pkg;
    localparam int STORE_BYTES = 64;
    localparam int AW = $clog2(STORE_BYTES);
    localparam logic [7:0] FRAME_HEAD = 8'h55;
    localparam logic [7:0] END_MARK = 8'hAA;
    localparam logic [7:0] MAX_LEN = 8'(STORE_BYTES - 4);

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_READ  = 2'd1,
        OP_FETCH = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    // Command passed from the front part to the back part through the queue.
    typedef struct packed {
        t_op        op;
        logic [7:0] data;
    } t_cmd;

    typedef struct packed {
        logic [7:0] byte_out;
        logic       status;
        logic       last;
        logic [5:0] pay_len;
    } t_res;
endpackage
`default_nettype wire

>>> design/rbfe_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface rbfe_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] operation;
    logic [7:0] byte_in;
    modport source (output valid, operation, byte_in, input ready);
    modport sink (input valid, operation, byte_in, output ready);
endinterface

interface rbfe_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_out;
    logic       status;
    logic       last;
    logic [5:0] pay_len;
    modport source (output valid, byte_out, status, last, pay_len, input ready);
    modport sink (input valid, byte_out, status, last, pay_len, output ready);
endinterface
`default_nettype wire

>>> design/ring_buffer_frame_extractor.sv
`timescale 1ns / 1ps
`default_nettype none
// Ring buffer with frame extraction.
// Input channel i_in carries operation (write, read, fetch frame) and byte_in.
// Output channel o_out carries byte_out, status, last and pay_len.
// A front queue of two entries accepts transactions; the back sequencer
// executes them one at a time against a 64-byte store with one read port.
// Write: no result. Read: one result, through the states S_RD and S_EOUT.
// Fetch: at each start position the header byte is checked first, then the
// length, then the payload sum, check byte and end mark; a found frame then
// emits its payload bytes one at a time.
// A full miss tries all 64 start positions and yields one no-frame result.
// After reset a clearing pass zeroes the whole store; transactions
// are queued meanwhile but not executed.
// A stalled receiver holds the output register; the sequencer waits and the
// queue then fills and drops i_in.ready.
module ring_buffer_frame_extractor
    import rbfe_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    rbfe_in_if.sink    i_in,
    rbfe_out_if.source o_out
);
    t_cmd cmd;
    logic cmd_valid, cmd_ready;

    rbfe_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(i_in),
        .o_cmd(cmd), .o_cmd_valid(cmd_valid), .i_cmd_ready(cmd_ready)
    );

    rbfe_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd),
        .i_cmd_valid(cmd_valid), .o_cmd_ready(cmd_ready), .o_out(o_out)
    );
endmodule
`default_nettype wire

>>> design/rbfe_front.sv
`timescale 1ns / 1ps
`default_nettype none
module rbfe_front
    import rbfe_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    rbfe_in_if.sink   i_in,
    output t_cmd      o_cmd,
    output logic      o_cmd_valid,
    input  wire logic i_cmd_ready
);
    // Two-entry queue; unused operation codes are dropped on entry.
    t_cmd r_q [2];
    logic [1:0] r_cnt;
    logic r_rd;
    logic push, pop;

    assign i_in.ready  = (r_cnt != 2'd2);
    assign push        = i_in.valid && i_in.ready && (t_op'(i_in.operation) != OP_NONE);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rd];
    assign pop         = o_cmd_valid && i_cmd_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_rd  <= 1'b0;
        end else begin
            if (push) r_q[r_rd ^ r_cnt[0]] <= '{op: t_op'(i_in.operation), data: i_in.byte_in};
            if (pop) r_rd <= ~r_rd;
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 2'd2) else $error("queue overflow");
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> r_cnt != 2'd0) else $error("pop from empty queue");
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == 2'd2 |-> !i_in.ready) else $error("ready while full");
endmodule
`default_nettype wire

>>> design/rbfe_back.sv
`timescale 1ns / 1ps
`default_nettype none
module rbfe_back
    import rbfe_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_cmd i_cmd,
    input  wire logic i_cmd_valid,
    output logic      o_cmd_ready,
    rbfe_out_if.source o_out
);
    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_RD, S_HD, S_LEN, S_SUM, S_CHK, S_TL, S_NEXT,
        S_EMIT, S_EOUT, S_WAIT
    } t_state;

    t_state r_state;
    logic [7:0] r_mem [STORE_BYTES];
    logic [7:0] r_rdata;
    logic [AW-1:0] r_addr, r_head, r_tail, r_fp, r_pos;
    logic [AW:0]   r_scan;
    logic [7:0] r_len, r_sum, r_chk, r_cnt;
    logic [AW-1:0] n_tail;
    logic r_ov;
    logic emit_now;
    t_res r_res;

    assign o_cmd_ready = (r_state == S_IDLE) && !r_ov;
    assign o_out.valid = r_ov;
    assign o_out.byte_out = r_res.byte_out;
    assign o_out.status = r_res.status;
    assign o_out.last = r_res.last;
    assign o_out.pay_len = r_res.pay_len;
    assign n_tail = r_tail + 1'b1;

    // A new result is loaded into the output register in this cycle.
    assign emit_now = (r_state == S_EOUT)
        || ((r_state == S_NEXT) && (r_scan == (AW+1)'(STORE_BYTES - 1))
            && (!r_ov || o_out.ready))
        || ((r_state == S_EMIT) && r_cnt[7] && (!r_ov || o_out.ready));

    // Store with one synchronous read port; read data is registered in r_rdata.
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[r_addr];
        if (r_state == S_CLEAR) r_mem[r_addr] <= '0;
        else if (r_state == S_IDLE && i_cmd_valid && o_cmd_ready && i_cmd.op == OP_WRITE)
            r_mem[r_tail] <= i_cmd.data;
    end

    // Sequencer: clearing pass, then one command at a time.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_addr <= '0;
            r_head <= '0;
            r_tail <= '0;
            r_fp <= '0;
            r_ov <= 1'b0;
        end else begin
            if (emit_now) r_ov <= 1'b1;
            else if (o_out.ready) r_ov <= 1'b0;
            case (r_state)
                S_CLEAR: begin
                    r_addr <= r_addr + 1'b1;
                    if (r_addr == AW'(STORE_BYTES - 1)) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (i_cmd_valid && o_cmd_ready) begin
                        case (i_cmd.op)
                            OP_WRITE: begin
                                if (n_tail == r_head) r_head <= r_head + 1'b1;
                                r_tail <= n_tail;
                            end
                            OP_READ: begin
                                r_addr <= r_head;
                                r_head <= r_head + 1'b1;
                                r_state <= S_RD;
                            end
                            OP_FETCH: begin
                                r_pos <= r_fp;
                                r_addr <= r_fp;
                                r_scan <= '0;
                                r_state <= S_WAIT;
                            end
                            default: ;
                        endcase
                    end
                end
                S_RD: begin
                    r_state <= S_EOUT;
                end
                S_EOUT: begin
                    r_res <= '{byte_out: r_rdata, status: 1'b0, last: 1'b1, pay_len: '0};
                    r_state <= S_IDLE;
                end
                S_WAIT: begin
                    r_addr <= r_pos + 1'b1;
                    r_state <= S_HD;
                end
                S_HD: begin
                    r_addr <= r_pos + AW'(2);
                    r_state <= (r_rdata == FRAME_HEAD) ? S_LEN : S_NEXT;
                end
                S_LEN: begin
                    r_len <= r_rdata;
                    r_sum <= FRAME_HEAD + r_rdata;
                    r_cnt <= '0;
                    r_addr <= r_addr + 1'b1;
                    r_state <= (r_rdata == 8'd0 || r_rdata > MAX_LEN) ? S_NEXT : S_SUM;
                end
                S_SUM: begin
                    r_sum <= r_sum + r_rdata;
                    r_cnt <= r_cnt + 1'b1;
                    r_addr <= r_addr + 1'b1;
                    if (r_cnt + 1'b1 == r_len) r_state <= S_CHK;
                end
                S_CHK: begin
                    r_chk <= r_rdata;
                    r_state <= S_TL;
                end
                S_TL: begin
                    if (r_rdata == END_MARK && (r_sum + r_rdata) == r_chk) begin
                        r_cnt <= '0;
                        r_addr <= r_pos + AW'(2);
                        r_fp <= r_pos + AW'(r_len) + AW'(4);
                        r_state <= S_EMIT;
                    end else begin
                        r_state <= S_NEXT;
                    end
                end
                S_NEXT: begin
                    if (r_scan == (AW+1)'(STORE_BYTES - 1)) begin
                        if (emit_now) begin
                            r_res <= '{byte_out: '0, status: 1'b1, last: 1'b1,
                                       pay_len: '0};
                            r_state <= S_IDLE;
                        end
                    end else begin
                        r_scan <= r_scan + 1'b1;
                        r_pos <= r_pos + 1'b1;
                        r_addr <= r_pos + 1'b1;
                        r_state <= S_WAIT;
                    end
                end
                S_EMIT: begin
                    // Address r_addr is issued before the wait state that precedes each byte.
                    if (r_cnt[7]) begin
                        if (emit_now) begin
                            r_res <= '{byte_out: r_rdata, status: 1'b0,
                                       last: (r_cnt[6:0] + 1'b1 == r_len[6:0]),
                                       pay_len: r_len[5:0]};
                            r_addr <= r_addr + 1'b1;
                            r_cnt <= {1'b0, r_cnt[6:0] + 1'b1};
                            if (r_cnt[6:0] + 1'b1 == r_len[6:0]) r_state <= S_IDLE;
                        end
                    end else begin
                        r_cnt <= {1'b1, r_cnt[6:0]};
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_ready |-> r_state == S_IDLE) else $error("command taken while busy");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && !o_out.ready |=> r_ov && $stable(r_res)) else $error("result lost");
    a_clear_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != S_CLEAR |=> r_state != S_CLEAR) else $error("clearing reentered");
endmodule
`default_nettype wire

>>> tb/rbfe_tb_if.sv
`timescale 1ns / 1ps
// The block's channel interfaces are declared with the design sources.
// This file keeps the testbench's own channel types beside them.
package rbfe_tb_types;
    import rbfe_pkg::*;

    // One input transaction as the testbench drives it.
    typedef struct packed {
        t_op        op;
        logic [7:0] data;
    } t_stim;
endpackage

>>> tb/testbench.sv
`timescale 1ns / 1ps
module testbench;
    import rbfe_pkg::*;
    import rbfe_tb_types::*;

    localparam int CYCLE_LIMIT = 2000000;
    localparam int SETTLE_CYCLES = 400;
    localparam int RANDOM_ITEMS = 280;

    logic i_clk;
    logic i_rst_n;
    rbfe_in_if  in_ch();
    rbfe_out_if out_ch();

    ring_buffer_frame_extractor DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch.sink),
        .o_out  (out_ch.source)
    );

    // Clock generation.
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Predictor state: a private copy of the ring store and its pointers.
    logic [7:0]      ring_mem [STORE_BYTES];
    logic [AW-1:0]   oldest_pos;
    logic [AW-1:0]   free_pos;
    logic [AW-1:0]   search_pos;
    t_res            pending_results[$];

    int  error_count;
    int  cycle_count;
    int  send_idle_pct;
    int  recv_idle_pct;

    // Payload length of a valid frame at start, or zero.
    function automatic int frame_len_at(logic [AW-1:0] start);
        logic [AW-1:0] p;
        logic [7:0]    sum;
        int            len;
        if (ring_mem[start] != FRAME_HEAD) return 0;
        len = ring_mem[AW'(start + 1)];
        if (len == 0 || len > STORE_BYTES - 4) return 0;
        sum = FRAME_HEAD + 8'(len);
        p = AW'(start + 2);
        for (int i = 0; i < len; i++) begin
            sum += ring_mem[p];
            p = AW'(p + 1);
        end
        sum += ring_mem[AW'(p + 1)];
        if (sum != ring_mem[p] || ring_mem[AW'(p + 1)] != END_MARK) return 0;
        return len;
    endfunction

    // Apply one accepted transaction to the ring copy and queue its results.
    task automatic predict_ring(t_stim s);
        logic [AW-1:0] pos;
        logic [AW-1:0] p;
        int            len;
        t_res          r;
        case (s.op)
            OP_WRITE: begin
                if (AW'(free_pos + 1) == oldest_pos) oldest_pos = AW'(oldest_pos + 1);
                ring_mem[free_pos] = s.data;
                free_pos = AW'(free_pos + 1);
            end
            OP_READ: begin
                r = '{byte_out: ring_mem[oldest_pos], status: 1'b0, last: 1'b1,
                      pay_len: 6'd0};
                oldest_pos = AW'(oldest_pos + 1);
                pending_results.push_back(r);
            end
            OP_FETCH: begin
                pos = search_pos;
                len = 0;
                for (int n = 0; n < STORE_BYTES && len == 0; n++) begin
                    len = frame_len_at(pos);
                    if (len == 0) pos = AW'(pos + 1);
                end
                if (len == 0) begin
                    r = '{byte_out: 8'd0, status: 1'b1, last: 1'b1, pay_len: 6'd0};
                    pending_results.push_back(r);
                end else begin
                    p = AW'(pos + 2);
                    for (int i = 0; i < len; i++) begin
                        r = '{byte_out: ring_mem[p], status: 1'b0,
                              last: (i + 1 == len), pay_len: 6'(len)};
                        pending_results.push_back(r);
                        p = AW'(p + 1);
                    end
                    search_pos = AW'(pos + len + 4);
                end
            end
            default: ;
        endcase
    endtask

    // Drive one transaction and wait for its acceptance.
    task automatic send_op(t_op op, logic [7:0] data);
        t_stim s;
        s.op = op;
        s.data = data;
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.operation <= op;
        in_ch.byte_in   <= data;
        do @(posedge i_clk); while (!in_ch.ready);
        predict_ring(s);
    endtask

    // Write a well-formed frame with a random payload.
    task automatic send_frame(int len);
        logic [7:0] sum;
        logic [7:0] b;
        sum = FRAME_HEAD + 8'(len) + END_MARK;
        send_op(OP_WRITE, FRAME_HEAD);
        send_op(OP_WRITE, 8'(len));
        for (int i = 0; i < len; i++) begin
            b = 8'($urandom_range(255));
            sum += b;
            send_op(OP_WRITE, b);
        end
        send_op(OP_WRITE, sum);
        send_op(OP_WRITE, END_MARK);
    endtask

    // Receiver: random stall, compare each transaction with the oldest expectation.
    always @(posedge i_clk) begin
        t_res exp_r;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (pending_results.size() == 0) begin
                    $display("%0t: unexpected result byte %h status %b last %b len %0d",
                             $time, out_ch.byte_out, out_ch.status, out_ch.last,
                             out_ch.pay_len);
                    error_count++;
                end else begin
                    exp_r = pending_results.pop_front();
                    if (exp_r.byte_out !== out_ch.byte_out) begin
                        $display("%0t: byte_out expected %h actual %h",
                                 $time, exp_r.byte_out, out_ch.byte_out);
                        error_count++;
                    end
                    if (exp_r.status !== out_ch.status) begin
                        $display("%0t: status expected %b actual %b",
                                 $time, exp_r.status, out_ch.status);
                        error_count++;
                    end
                    if (exp_r.last !== out_ch.last) begin
                        $display("%0t: last expected %b actual %b",
                                 $time, exp_r.last, out_ch.last);
                        error_count++;
                    end
                    if (exp_r.pay_len !== out_ch.pay_len) begin
                        $display("%0t: pay_len expected %0d actual %0d",
                                 $time, exp_r.pay_len, out_ch.pay_len);
                        error_count++;
                    end
                end
            end
            out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog on total run length.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("ring_buffer_frame_extractor: mismatch");
            $finish;
        end
    end

    // Directed table: operation, byte, and for the read and fetch on the fresh store the known result.
    typedef struct {
        t_op        op;
        logic [7:0] data;
        logic       known;
        t_res       res;
    } t_row;

    t_row directed_rows[$];

    initial begin
        t_row row;
        int   settle;
        int   flen;
        error_count = 0;
        cycle_count = 0;
        send_idle_pct = 28;
        recv_idle_pct = 56;
        i_rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.operation = OP_WRITE;
        in_ch.byte_in = 8'd0;
        out_ch.ready = 1'b0;
        for (int i = 0; i < STORE_BYTES; i++) ring_mem[i] = 8'd0;
        oldest_pos = '0;
        free_pos = '0;
        search_pos = '0;

        // Fresh store: read yields zero, fetch finds nothing.
        directed_rows.push_back('{OP_READ, 8'h00, 1'b1, '{8'h00, 1'b0, 1'b1, 6'd0}});
        directed_rows.push_back('{OP_FETCH, 8'h00, 1'b1, '{8'h00, 1'b1, 1'b1, 6'd0}});
        directed_rows.push_back('{OP_NONE, 8'hFF, 1'b0, '{8'h00, 1'b0, 1'b0, 6'd0}});
        // Extremes of the data byte, then a one-byte frame: 55 01 AA AA AA.
        directed_rows.push_back('{OP_WRITE, 8'hFF, 1'b0, '{8'h00, 1'b0, 1'b0, 6'd0}});
        directed_rows.push_back('{OP_WRITE, 8'h00, 1'b0, '{8'h00, 1'b0, 1'b0, 6'd0}});
        directed_rows.push_back('{OP_WRITE, FRAME_HEAD, 1'b0, '{8'h00, 1'b0, 1'b0, 6'd0}});
        directed_rows.push_back('{OP_WRITE, 8'h01, 1'b0, '{8'h00, 1'b0, 1'b0, 6'd0}});
        directed_rows.push_back('{OP_WRITE, 8'hAA, 1'b0, '{8'h00, 1'b0, 1'b0, 6'd0}});
        directed_rows.push_back('{OP_WRITE, 8'hAA, 1'b0, '{8'h00, 1'b0, 1'b0, 6'd0}});
        directed_rows.push_back('{OP_WRITE, END_MARK, 1'b0, '{8'h00, 1'b0, 1'b0, 6'd0}});
        directed_rows.push_back('{OP_FETCH, 8'h00, 1'b0, '{8'h00, 1'b0, 1'b0, 6'd0}});
        directed_rows.push_back('{OP_FETCH, 8'h00, 1'b0, '{8'h00, 1'b0, 1'b0, 6'd0}});
        directed_rows.push_back('{OP_READ, 8'h00, 1'b0, '{8'h00, 1'b0, 1'b0, 6'd0}});
        directed_rows.push_back('{OP_READ, 8'h00, 1'b0, '{8'h00, 1'b0, 1'b0, 6'd0}});
        // Oversized length byte and a bad checksum are both rejected.
        directed_rows.push_back('{OP_WRITE, FRAME_HEAD, 1'b0, '{8'h00, 1'b0, 1'b0, 6'd0}});
        directed_rows.push_back('{OP_WRITE, MAX_LEN + 8'd1, 1'b0, '{8'h00, 1'b0, 1'b0, 6'd0}});
        directed_rows.push_back('{OP_WRITE, FRAME_HEAD, 1'b0, '{8'h00, 1'b0, 1'b0, 6'd0}});
        directed_rows.push_back('{OP_WRITE, 8'h01, 1'b0, '{8'h00, 1'b0, 1'b0, 6'd0}});
        directed_rows.push_back('{OP_WRITE, 8'h11, 1'b0, '{8'h00, 1'b0, 1'b0, 6'd0}});
        directed_rows.push_back('{OP_WRITE, 8'h00, 1'b0, '{8'h00, 1'b0, 1'b0, 6'd0}});
        directed_rows.push_back('{OP_WRITE, END_MARK, 1'b0, '{8'h00, 1'b0, 1'b0, 6'd0}});
        directed_rows.push_back('{OP_FETCH, 8'h00, 1'b0, '{8'h00, 1'b0, 1'b0, 6'd0}});

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: known rows check their typed value against the predictor too.
        foreach (directed_rows[k]) begin
            row = directed_rows[k];
            send_op(row.op, row.data);
            if (row.known && pending_results.size() > 0 &&
                pending_results[$] != row.res) begin
                $display("%0t: row %0d expected %p actual prediction %p",
                         $time, k, row.res, pending_results[$]);
                error_count++;
            end
        end

        // Random part in three idling phases.
        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 28 : (phase == 1) ? 56 : 0;
            recv_idle_pct = (phase == 0) ? 56 : (phase == 1) ? 28 : 0;
            for (int n = 0; n < RANDOM_ITEMS / 3; ) begin
                case ($urandom_range(9))
                    0, 1, 2, 3: begin
                        // Mostly short frames, now and then the longest.
                        flen = ($urandom_range(15) == 0) ? STORE_BYTES - 4
                                                         : int'($urandom_range(1, 8));
                        send_frame(flen);
                        n += flen + 4;
                    end
                    4, 5: begin
                        send_op(OP_FETCH, 8'($urandom_range(255)));
                        n++;
                    end
                    6: begin
                        send_op(OP_READ, 8'($urandom_range(255)));
                        n++;
                    end
                    7: begin
                        send_op(OP_NONE, 8'($urandom_range(255)));
                        n++;
                    end
                    default: begin
                        // Noise, with frame markers now and then.
                        send_op(OP_WRITE, ($urandom_range(3) == 0) ? FRAME_HEAD
                                                                   : 8'($urandom_range(255)));
                        n++;
                    end
                endcase
            end
        end
        in_ch.valid <= 1'b0;

        // Drain, then let any trailing work finish.
        while (pending_results.size() != 0) @(posedge i_clk);
        settle = 0;
        while (settle < SETTLE_CYCLES) begin
            @(posedge i_clk);
            settle++;
        end

        if (error_count == 0 && pending_results.size() == 0) begin
            $display("ring_buffer_frame_extractor: match");
        end else begin
            $display("ring_buffer_frame_extractor: mismatch");
        end
        $finish;
    end
endmodule

>>> files.f
design/rbfe_pkg.sv
design/rbfe_if.sv
design/rbfe_front.sv
design/rbfe_back.sv
design/ring_buffer_frame_extractor.sv
tb/rbfe_tb_if.sv
tb/testbench.sv
